// File: hdl/rnf_pkg.sv
// Shared constants and the digit-to-ASCII table for the radix number formatter.
`timescale 1ns / 1ps
`default_nettype none

package rnf_pkg;

    localparam int WIDTH_LIMIT_DEFAULT = 31;

    localparam int DIG_DEPTH = 11;
    localparam int ND_W      = $clog2(DIG_DEPTH + 1);

    localparam logic [1:0] RADIX_OCT   = 2'd0;
    localparam logic [1:0] RADIX_DEC   = 2'd1;
    localparam logic [1:0] RADIX_HEX   = 2'd2;
    localparam logic [1:0] RADIX_RESET = RADIX_HEX;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_QUERY = 8'h3f;

    localparam logic [31:0] MOST_NEG   = 32'h8000_0000;
    localparam logic [31:0] RECIP_10   = 32'hcccc_cccd;
    localparam int          RECIP_SHIFT = 35;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        unique case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'ha: c = 8'h61;
            4'hb: c = 8'h62;
            4'hc: c = 8'h63;
            4'hd: c = 8'h64;
            4'he: c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/radix_number_formatter_core.sv
// Radix number formatter: converts one 32-bit value to a run of ASCII characters.
// Conversion yields up to 11 digits (octal), 8 (hex) or 10 (decimal, one multiply
// by the reciprocal of ten and one remainder step per digit), then one layout step.
// Then one character per cycle, up to 32; the last character beat sits in the first
// idle cycle, so the next value can be accepted while that beat is out.
// Receiver cannot stall. Asynchronous active-low reset idles and selects hexadecimal.
`timescale 1ns / 1ps
`default_nettype none

module radix_number_formatter_core
    import rnf_pkg::*;
#(
    parameter int WIDTH_LIMIT = WIDTH_LIMIT_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] value,
    input  wire logic [4:0]  field_width,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_data,
    output logic             char_strobe,
    output logic [7:0]       char_code,
    output logic             last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_MUL,
        S_DIV,
        S_LAYOUT,
        S_SPACE,
        S_PREFIX,
        S_DIGIT
    } state_t;

    localparam logic [5:0] WL6 = 6'(WIDTH_LIMIT);

    state_t            state_reg, state_next;
    logic [1:0]        radix_reg, radix_next;
    logic [ND_W-1:0]   nd_reg, nd_next;
    logic              neg_reg, neg_next;
    logic              spec_reg, spec_next;
    logic [5:0]        spc_reg, spc_next;
    logic              has_pre_reg, has_pre_next;
    logic              strobe_reg, strobe_next;
    logic [7:0]        code_reg, code_next;
    logic              last_reg, last_next;

    logic [1:0]        mode_reg, mode_next;
    logic [4:0]        w_reg, w_next;
    logic [31:0]       m_reg, m_next;
    logic [63:0]       prod_reg, prod_next;
    logic [7:0]        pre_reg, pre_next;
    logic [3:0]        dig_reg [DIG_DEPTH];
    logic [3:0]        dig_next [DIG_DEPTH];

    logic [31:0]       shifted;
    logic [3:0]        new_dig;
    logic [28:0]       quot;
    logic [3:0]        q10_lo;
    logic [5:0]        base, sub;
    logic [5:0]        spc_calc;
    logic              pre_calc;
    logic [7:0]        pre_char_calc;
    logic              is_oct, is_dec;

    assign busy        = (state_reg != S_IDLE);
    assign char_strobe = strobe_reg;
    assign char_code   = code_reg;
    assign last        = last_reg;

    assign is_oct  = (mode_reg == RADIX_OCT);
    assign is_dec  = (mode_reg == RADIX_DEC);
    assign shifted = is_oct ? (m_reg >> 3) : (m_reg >> 4);
    assign new_dig = is_oct ? {1'b0, m_reg[2:0]} : m_reg[3:0];
    assign quot    = prod_reg[63:RECIP_SHIFT];
    assign q10_lo  = {quot[0], 3'b000} + {quot[2:0], 1'b0};

    always_comb
    begin
        priority if (is_oct)
        begin
            base          = {1'b0, w_reg};
            sub           = 6'(nd_reg);
            pre_calc      = 1'b1;
            pre_char_calc = ASCII_ZERO;
        end
        else if (is_dec && spec_reg)
        begin
            base          = {1'b0, w_reg};
            sub           = 6'd1;
            pre_calc      = 1'b1;
            pre_char_calc = ASCII_QUERY;
        end
        else if (is_dec)
        begin
            base          = {1'b0, w_reg} + 6'd1;
            sub           = 6'(nd_reg) + {5'd0, neg_reg};
            pre_calc      = neg_reg;
            pre_char_calc = ASCII_MINUS;
        end
        else
        begin
            base          = {1'b0, w_reg} + 6'd1;
            sub           = 6'(nd_reg);
            pre_calc      = 1'b0;
            pre_char_calc = ASCII_MINUS;
        end
        spc_calc = (base > sub) ? (base - sub) : 6'd0;
    end

    always_comb
    begin
        state_next   = state_reg;
        radix_next   = cfg_write ? cfg_data : radix_reg;
        nd_next      = nd_reg;
        neg_next     = neg_reg;
        spec_next    = spec_reg;
        spc_next     = spc_reg;
        has_pre_next = has_pre_reg;
        strobe_next  = 1'b0;
        code_next    = code_reg;
        last_next    = 1'b0;
        mode_next    = mode_reg;
        w_next       = w_reg;
        m_next       = m_reg;
        prod_next    = prod_reg;
        pre_next     = pre_reg;
        dig_next     = dig_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = radix_reg;
                    w_next    = ({1'b0, field_width} > WL6) ? WL6[4:0] : field_width;
                    nd_next   = '0;
                    neg_next  = 1'b0;
                    spec_next = 1'b0;
                    m_next    = value;
                    if (radix_reg == RADIX_DEC)
                    begin
                        if (value == MOST_NEG)
                        begin
                            spec_next  = 1'b1;
                            state_next = S_LAYOUT;
                        end
                        else
                        begin
                            neg_next   = value[31];
                            m_next     = value[31] ? (32'd0 - value) : value;
                            state_next = S_MUL;
                        end
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (is_oct && (m_reg == 32'd0))
                begin
                    state_next = S_LAYOUT;
                end
                else
                begin
                    for (int i = DIG_DEPTH - 1; i > 0; i--)
                        dig_next[i] = dig_reg[i-1];
                    dig_next[0] = new_dig;
                    nd_next     = nd_reg + ND_W'(1);
                    m_next      = shifted;
                    if (shifted == 32'd0)
                        state_next = S_LAYOUT;
                end
            end
            S_MUL:
            begin
                prod_next  = m_reg * RECIP_10;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                for (int i = DIG_DEPTH - 1; i > 0; i--)
                    dig_next[i] = dig_reg[i-1];
                dig_next[0] = m_reg[3:0] - q10_lo;
                nd_next     = nd_reg + ND_W'(1);
                m_next      = {3'b000, quot};
                state_next  = (quot == 29'd0) ? S_LAYOUT : S_MUL;
            end
            S_LAYOUT:
            begin
                spc_next     = spc_calc;
                has_pre_next = pre_calc;
                pre_next     = pre_char_calc;
                priority if (spc_calc != 6'd0)
                    state_next = S_SPACE;
                else if (pre_calc)
                    state_next = S_PREFIX;
                else
                    state_next = S_DIGIT;
            end
            S_SPACE:
            begin
                strobe_next = 1'b1;
                code_next   = ASCII_SPACE;
                spc_next    = spc_reg - 6'd1;
                if (spc_reg == 6'd1)
                    state_next = has_pre_reg ? S_PREFIX : S_DIGIT;
            end
            S_PREFIX:
            begin
                strobe_next = 1'b1;
                code_next   = pre_reg;
                last_next   = (nd_reg == '0);
                state_next  = (nd_reg == '0) ? S_IDLE : S_DIGIT;
            end
            S_DIGIT:
            begin
                strobe_next = 1'b1;
                code_next   = digit_char(dig_reg[0]);
                for (int i = 0; i < DIG_DEPTH - 1; i++)
                    dig_next[i] = dig_reg[i+1];
                nd_next     = nd_reg - ND_W'(1);
                last_next   = (nd_reg == ND_W'(1));
                if (nd_reg == ND_W'(1))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            radix_reg   <= RADIX_RESET;
            nd_reg      <= '0;
            neg_reg     <= 1'b0;
            spec_reg    <= 1'b0;
            spc_reg     <= '0;
            has_pre_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            code_reg    <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            radix_reg   <= radix_next;
            nd_reg      <= nd_next;
            neg_reg     <= neg_next;
            spec_reg    <= spec_next;
            spc_reg     <= spc_next;
            has_pre_reg <= has_pre_next;
            strobe_reg  <= strobe_next;
            code_reg    <= code_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        w_reg    <= w_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        pre_reg  <= pre_next;
        dig_reg  <= dig_next;
    end

endmodule

`default_nettype wire

// File: hdl/rnf_checker.sv
// Port-level assertions for the radix number formatter and their bind.
`timescale 1ns / 1ps
`default_nettype none

module rnf_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic char_strobe,
    input wire logic last
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !char_strobe))
        else $error("accepted beat did not raise busy or left a stale character");

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> char_strobe)
        else $error("last flag without a character beat");

    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (char_strobe && !last) |=> char_strobe)
        else $error("gap inside a character run");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (char_strobe && !last) |-> busy)
        else $error("idle while a character run is unfinished");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (char_strobe && last) |=> !char_strobe)
        else $error("character beat directly after the last one");

endmodule

bind radix_number_formatter_core rnf_checker u_rnf_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .char_strobe (char_strobe),
    .last        (last)
);

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for the radix number formatter: directed and random numbers checked per character.
`timescale 1ns / 1ps

module tb_top
    import rnf_pkg::*;
();

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         DRAIN_CYCLES  = 60;
    localparam int         PHASE_COUNT   = 8;
    localparam int         PHASE_ITEMS   = 19;
    localparam logic [1:0] RADIX_SPARE   = 2'd3;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;

    typedef struct packed {
        logic [7:0] code;
        logic       tail;
    } char_beat_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [31:0] value       = '0;
    logic [4:0]  field_width = '0;
    logic        cfg_write   = 1'b0;
    logic [1:0]  cfg_data    = '0;
    logic        char_strobe;
    logic [7:0]  char_code;
    logic        last;

    char_beat_t  expected_chars[$];
    logic [1:0]  radix_model = RADIX_RESET;
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          pacing_on   = 1'b1;

    radix_number_formatter_core u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .field_width (field_width),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .char_strobe (char_strobe),
        .char_code   (char_code),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_chars(input logic [31:0] v, input logic [4:0] w);
        logic [7:0]  text[$];
        logic [31:0] m;
        logic [3:0]  d;
        int          target;
        target = int'(w) + 1;
        m = v;
        if (radix_model == RADIX_OCT)
        begin
            while (m != 0)
            begin
                text.push_front(ASCII_ZERO + {5'd0, m[2:0]});
                m = m >> 3;
            end
            text.push_front(ASCII_ZERO);
        end
        else if (radix_model == RADIX_DEC && v == MOST_NEG)
        begin
            text.push_front(ASCII_QUERY);
            target = int'(w);
        end
        else if (radix_model == RADIX_DEC)
        begin
            if (v[31])
                m = -v;
            do
            begin
                text.push_front(ASCII_ZERO + 8'(m % 10));
                m = m / 10;
            end
            while (m != 0);
            if (v[31])
                text.push_front(ASCII_MINUS);
        end
        else
        begin
            do
            begin
                d = m[3:0];
                if (d < 4'd10)
                    text.push_front(ASCII_ZERO + {4'd0, d});
                else
                    text.push_front(ASCII_LOWER_A + {4'd0, d} - 8'd10);
                m = m >> 4;
            end
            while (m != 0);
        end
        while (text.size() < target)
            text.push_front(ASCII_SPACE);
        foreach (text[i])
            expected_chars.push_back('{code: text[i], tail: (i == text.size() - 1)});
    endfunction

    // hold start until the beat is taken, then either keep the burst going or drop into a gap
    task automatic send_number(input logic [31:0] v, input logic [4:0] w);
        start       <= 1'b1;
        value       <= v;
        field_width <= w;
        do
            @(posedge clk);
        while (busy);
        predict_chars(v, w);
        if (burst_left > 0)
            burst_left--;
        else if (pacing_on)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(10, 70)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic set_radix(input logic [1:0] r);
        start <= 1'b0;
        wait (expected_chars.size() == 0);
        do
            @(posedge clk);
        while (busy);
        cfg_write <= 1'b1;
        cfg_data  <= r;
        @(posedge clk);
        cfg_write <= 1'b0;
        radix_model = r;
    endtask

    task automatic test_reset_hex();
        send_number(32'h0000_0000, 5'd0);
        send_number(32'h0000_0000, 5'd31);
        send_number(32'hffff_ffff, 5'd0);
        send_number(32'hffff_ffff, 5'd31);
        send_number(32'h0a0b_0c0d, 5'd5);
    endtask

    task automatic test_octal();
        set_radix(RADIX_OCT);
        send_number(32'h0000_0000, 5'd0);
        send_number(32'h0000_0000, 5'd31);
        send_number(32'hffff_ffff, 5'd0);
        send_number(32'hffff_ffff, 5'd31);
        send_number(32'h0000_0008, 5'd3);
    endtask

    task automatic test_decimal();
        set_radix(RADIX_DEC);
        send_number(32'h0000_0000, 5'd0);
        send_number(MOST_NEG, 5'd0);
        send_number(MOST_NEG, 5'd31);
        send_number(32'hffff_ffff, 5'd0);
        send_number(32'h7fff_ffff, 5'd31);
        send_number(32'h8000_0001, 5'd5);
        send_number(32'd12345, 5'd31);
    endtask

    task automatic test_spare_radix();
        set_radix(RADIX_SPARE);
        send_number(32'hdead_beef, 5'd10);
        send_number(32'h0000_0000, 5'd1);
        send_number(32'h0123_4567, 5'd2);
    endtask

    task automatic test_random_numbers();
        logic [1:0]  order[4];
        logic [31:0] v;
        logic [4:0]  w;
        int          phase;
        int          n;
        order = '{RADIX_DEC, RADIX_OCT, RADIX_HEX, RADIX_SPARE};
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            set_radix(phase < 4 ? order[phase] : 2'($urandom_range(0, 3)));
            pacing_on = (phase != 5);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 5))
                    0: v = $urandom;
                    1: v = $urandom_range(0, 15);
                    2: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
                    3: v = MOST_NEG + $urandom_range(0, 2) - 32'd1;
                    4: v = -$urandom_range(1, 1000);
                    default: v = $urandom >> $urandom_range(0, 31);
                endcase
                case ($urandom_range(0, 3))
                    0: w = 5'd0;
                    1: w = 5'd31;
                    default: w = 5'($urandom_range(0, 31));
                endcase
                send_number(v, w);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (char_strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected char: expected none, actual %h last %b",
                         $time, char_code, last);
                mismatches++;
            end
            else
            begin
                if (char_code !== expected_chars[0].code || last !== expected_chars[0].tail)
                begin
                    $display("%0t: char mismatch: expected %h last %b, actual %h last %b",
                             $time, expected_chars[0].code, expected_chars[0].tail,
                             char_code, last);
                    mismatches++;
                end
                void'(expected_chars.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_hex();
        test_octal();
        test_decimal();
        test_spare_radix();
        test_random_numbers();
        start <= 1'b0;
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
